/* rtl/rocauc_pkg.sv */
// Package: shared types, constants and state codes for the ROC/AUC engine.
package rocauc_pkg;

  localparam int MaxSamplesDefault = 4096;
  localparam int ThresholdsDefault = 20;
  localparam logic [15:0] PosLabelReset = 16'd1;
  localparam logic [15:0] NegLabelReset = 16'd2;

  typedef enum logic [1:0] {
    KIND_POINT = 2'd0,
    KIND_AREA  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [0:0] {
    REG_POS_LABEL = 1'b0,
    REG_NEG_LABEL = 1'b1
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_THR_MUL,
    ST_THR_DIV,
    ST_SCAN,
    ST_SCAN_DRAIN,
    ST_RATE_DIV,
    ST_AREA_MUL,
    ST_POINT_OUT,
    ST_AREA_OUT,
    ST_ERR_OUT
  } state_t;

  typedef struct packed {
    logic [31:0] sample_value;
    logic [15:0] sample_label;
    logic        final_sample;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] threshold_value;
    logic [16:0] true_positive_rate;
    logic [16:0] false_positive_rate;
    logic [16:0] area_under_curve;
    logic        run_end;
  } out_item_t;

  // Sample store port bundle.
  typedef struct packed {
    logic        wr_en;
    logic        rd_en;
  } mem_ctl_t;

endpackage

/* rtl/rocauc_divider.sv */
// Module: restoring divider, one quotient bit per cycle.
module rocauc_divider #(
  parameter int NumW = 64,
  parameter int DenW = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [NumW-1:0] numer,
  input  logic [DenW-1:0] denom,
  output logic            busy,
  output logic            done,
  output logic [NumW-1:0] quot
);
  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0] q;
  logic [DenW:0]   rem;
  logic [DenW-1:0] d;
  logic [CntW-1:0] cnt;
  logic [DenW:0]   shifted;
  logic [DenW:0]   diff;

  assign shifted = {rem[DenW-1:0], q[NumW-1]};
  assign diff    = shifted - {1'b0, d};
  assign quot    = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        q    <= numer;
        rem  <= '0;
        d    <= denom;
        cnt  <= CntW'(NumW);
      end else if (busy) begin
        if (!diff[DenW]) begin
          rem <= diff;
          q   <= {q[NumW-2:0], 1'b1};
        end else begin
          rem <= shifted;
          q   <= {q[NumW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

/* rtl/rocauc_store.sv */
// Module: sample store memory, one write and one registered read port.
module rocauc_store #(
  parameter int AddrW = 12,
  parameter int Depth = 4096
) (
  input  logic             clk,
  input  rocauc_pkg::mem_ctl_t ctl,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [32:0]      wr_data,
  input  logic [AddrW-1:0] rd_addr,
  output logic [32:0]      rd_data
);
  import rocauc_pkg::*;

  logic [32:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

/* rtl/roc_curve_auc_engine_top.sv */
// Top level: ROC curve points and trapezoid AUC over a stored sample set.
// Loading: one sample transfer per cycle, no result until the final sample.
// Per threshold: form it, scan the store, divide for the true and then the false
// positive rate, update the area, then offer the point transfer; the area result
// follows the last point. An error result is offered from ST_THR_MUL on a bad run.
// rst is synchronous: labels return to 1 and 2, counters, bounds, area and state clear.
module roc_curve_auc_engine_top #(
  parameter int MAX_SAMPLES = rocauc_pkg::MaxSamplesDefault,
  parameter int THRESHOLDS  = rocauc_pkg::ThresholdsDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rocauc_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rocauc_pkg::out_item_t out_data,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [15:0]           cfg_wdata
);
  import rocauc_pkg::*;

  localparam int AddrW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CntW  = $clog2(MAX_SAMPLES + 1);
  localparam int IdxW  = $clog2(THRESHOLDS);
  localparam int DivW  = CntW + 17;   // numerator width: hits<<16 plus half the total
  localparam int DenW  = CntW;
  // span / THRESHOLDS by reciprocal multiplication, exact for any 32-bit span
  localparam int LogT  = $clog2(THRESHOLDS);
  localparam logic [32:0] Recip =
    33'(((64'd1 << (32 + LogT)) + 64'(THRESHOLDS - 1)) / 64'(THRESHOLDS));

  // Configuration registers
  logic [15:0] pos_label, neg_label;
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_label <= PosLabelReset;
      neg_label <= NegLabelReset;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_POS_LABEL: pos_label <= cfg_wdata;
        REG_NEG_LABEL: neg_label <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Run state
  state_t state, state_next;
  logic [CntW-1:0] fill_count, pos_count, neg_count;
  logic [31:0] lowest, highest;
  logic        overflow;
  logic [33:0] area_acc;
  logic [IdxW-1:0] thr_idx;
  logic [31:0] thr;
  logic [CntW-1:0] scan_addr;
  logic [CntW-1:0] tp, fp;
  logic        rd_pending;
  logic [16:0] tpr, fpr, prev_t, prev_f;
  logic        rate_sel;     // 0: tpr divide, 1: fpr divide

  // Threshold offsets: off = span_q*i + floor(span_r*i/THRESHOLDS), rr = remainder
  logic [63:0]     rprod;
  logic [31:0]     span, span_q, off;
  logic [LogT-1:0] span_r, rr;
  logic            thr_step;
  logic [32:0]     qhi;
  logic [LogT:0]   rsum;
  logic            carry;

  assign span  = highest - lowest;
  assign qhi   = {1'b0, rprod[63:32]} + (Recip[32] ? {1'b0, span} : 33'd0);
  assign rsum  = {1'b0, rr} + {1'b0, span_r};
  assign carry = rsum >= (LogT+1)'(THRESHOLDS);

  // Load path
  logic in_fire, is_pos, is_neg, matched, full;
  assign in_ready = (state == ST_LOAD) && !out_valid;
  assign in_fire  = in_valid && in_ready;
  assign is_pos   = in_data.sample_label == pos_label;
  assign is_neg   = !is_pos && (in_data.sample_label == neg_label);
  assign matched  = is_pos || is_neg;
  assign full     = fill_count == CntW'(MAX_SAMPLES);

  // Store
  mem_ctl_t mctl;
  logic [32:0] rd_data;
  assign mctl.wr_en = in_fire && matched && !full;
  assign mctl.rd_en = (state == ST_SCAN);

  rocauc_store #(.AddrW(AddrW), .Depth(MAX_SAMPLES)) u_store (
    .clk     (clk),
    .ctl     (mctl),
    .wr_addr (fill_count[AddrW-1:0]),
    .wr_data ({is_pos, in_data.sample_value}),
    .rd_addr (scan_addr[AddrW-1:0]),
    .rd_data (rd_data)
  );

  // Rate divider: tpr started from the drain cycle, fpr from the tpr done cycle
  logic            div_start, div_busy, div_done;
  logic [DivW-1:0] div_num, div_quot;
  logic [DenW-1:0] div_den;
  logic [CntW-1:0] rate_hits, rate_total;

  assign rate_hits  = (state == ST_RATE_DIV) ? fp : tp;
  assign rate_total = (state == ST_RATE_DIV) ? neg_count : pos_count;

  always_comb begin
    div_num = {1'b0, rate_hits, 16'h0} + DivW'(rate_total >> 1);
    div_den = rate_total;
  end

  rocauc_divider #(.NumW(DivW), .DenW(DenW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (div_num),
    .denom (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  logic last_idx, first_idx, bad_run;
  assign first_idx = thr_idx == '0;
  assign last_idx  = thr_idx == IdxW'(THRESHOLDS - 1);
  assign bad_run   = overflow || pos_count == '0 || neg_count == '0;

  // Next-state logic
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD:       if (in_fire && in_data.final_sample) state_next = ST_THR_MUL;
      ST_THR_MUL:    state_next = bad_run ? ST_ERR_OUT :
                                  last_idx ? ST_SCAN : ST_THR_DIV;
      ST_THR_DIV:    if (!first_idx || thr_step) state_next = ST_SCAN;
      ST_SCAN:       if (scan_addr == fill_count) state_next = ST_SCAN_DRAIN;
      ST_SCAN_DRAIN: state_next = ST_RATE_DIV;
      ST_RATE_DIV:   if (div_done && rate_sel) state_next = ST_AREA_MUL;
      ST_AREA_MUL:   state_next = ST_POINT_OUT;
      ST_POINT_OUT:  if (out_ready) state_next = last_idx ? ST_AREA_OUT : ST_THR_MUL;
      ST_AREA_OUT:   if (out_ready) state_next = ST_LOAD;
      ST_ERR_OUT:    if (out_ready) state_next = ST_LOAD;
      default:       state_next = ST_LOAD;
    endcase
  end

  // Output decode
  always_comb begin
    out_valid = 1'b0;
    out_data  = '0;
    div_start = 1'b0;
    unique case (state)
      ST_SCAN_DRAIN: div_start = 1'b1;
      ST_RATE_DIV:   div_start = div_done && !rate_sel;
      ST_POINT_OUT: begin
        out_valid = 1'b1;
        out_data.result_kind         = KIND_POINT;
        out_data.threshold_value     = thr;
        out_data.true_positive_rate  = tpr;
        out_data.false_positive_rate = fpr;
      end
      ST_AREA_OUT: begin
        out_valid = 1'b1;
        out_data.result_kind      = KIND_AREA;
        out_data.area_under_curve = 17'((area_acc + 34'h10000) >> 17);
        out_data.run_end          = 1'b1;
      end
      ST_ERR_OUT: begin
        out_valid = 1'b1;
        out_data.result_kind = KIND_ERROR;
        out_data.run_end     = 1'b1;
      end
      default: ;
    endcase
  end

  // Datapath registers
  logic [17:0] tsum;
  logic [16:0] fdiff;
  assign tsum  = {1'b0, prev_t} + {1'b0, tpr};
  assign fdiff = (prev_f >= fpr) ? (prev_f - fpr) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      fill_count <= '0;
      pos_count  <= '0;
      neg_count  <= '0;
      lowest     <= '1;
      highest    <= '0;
      overflow   <= 1'b0;
      area_acc   <= '0;
      thr_idx    <= '0;
      scan_addr  <= '0;
      rd_pending <= 1'b0;
      rate_sel   <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_LOAD: begin
          thr_idx <= '0;
          if (in_fire && matched) begin
            if (full) begin
              overflow <= 1'b1;
            end else begin
              fill_count <= fill_count + 1'b1;
              if (is_pos) pos_count <= pos_count + 1'b1;
              else        neg_count <= neg_count + 1'b1;
              if (in_data.sample_value < lowest)  lowest  <= in_data.sample_value;
              if (in_data.sample_value > highest) highest <= in_data.sample_value;
            end
          end
        end
        ST_THR_MUL: begin
          scan_addr  <= '0;
          tp <= '0;
          fp <= '0;
          rd_pending <= 1'b0;
          rate_sel   <= 1'b0;
          thr_step   <= 1'b0;
          if (first_idx) begin
            // span x reciprocal, 32x32 partial; top bit added next cycle
            thr   <= lowest;
            rprod <= 64'(span) * 64'(Recip[31:0]);
            off   <= '0;
            rr    <= '0;
          end else if (last_idx) begin
            thr <= highest;
          end else begin
            off <= off + span_q + 32'(carry);
            rr  <= carry ? LogT'(rsum - (LogT+1)'(THRESHOLDS)) : rsum[LogT-1:0];
          end
        end
        ST_THR_DIV: begin
          if (!first_idx) begin
            thr <= lowest + off;
          end else if (!thr_step) begin
            span_q   <= 32'(qhi >> LogT);
            thr_step <= 1'b1;
          end else begin
            span_r <= LogT'(span - 32'(span_q * 32'(THRESHOLDS)));
          end
        end
        ST_SCAN, ST_SCAN_DRAIN: begin
          if (state == ST_SCAN) scan_addr <= scan_addr + 1'b1;
          rd_pending <= (state == ST_SCAN) && (scan_addr != fill_count);
          if (rd_pending && rd_data[31:0] >= thr) begin
            if (rd_data[32]) tp <= tp + 1'b1;
            else             fp <= fp + 1'b1;
          end
        end
        ST_RATE_DIV: if (div_done) begin
          if (!rate_sel) tpr <= div_quot[16:0];
          else           fpr <= div_quot[16:0];
          rate_sel <= 1'b1;
        end
        ST_AREA_MUL: if (!first_idx) area_acc <= area_acc + 34'(tsum * fdiff);
        ST_POINT_OUT: if (out_ready) begin
          prev_t  <= tpr;
          prev_f  <= fpr;
          thr_idx <= thr_idx + 1'b1;
        end
        ST_AREA_OUT, ST_ERR_OUT: if (out_ready) begin
          fill_count <= '0;
          pos_count  <= '0;
          neg_count  <= '0;
          lowest     <= '1;
          highest    <= '0;
          overflow   <= 1'b0;
          area_acc   <= '0;
        end
        default: ;
      endcase
    end
  end
endmodule
